/* src/cowrc_pkg.sv */
// Shared types and constants for the copy-on-write page sharer count engine.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cowrc_pkg;

  // Field widths of the entry and the stream payloads.
  localparam int PTE_W       = 32;
  localparam int ADDR_W      = 32;
  localparam int FRAME_W     = 20;
  localparam int FLAG_W      = 12;
  localparam int FRAME_SHIFT = 12;
  localparam int ACTION_W    = 2;
  localparam int OUTCOME_W   = 4;
  localparam int REPORT_W    = 8;
  localparam int S_TDATA_W   = 88;
  localparam int M_TDATA_W   = 48;

  // Flag bit positions inside the entry.
  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;

  // Defaults for the top-level parameters.
  localparam int PAGE_COUNT_DEF  = 65536;
  localparam int SHARE_BIT_DEF   = 9;
  localparam int COUNT_WIDTH_DEF = 8;

  // Action codes carried on the input tuser.
  localparam logic [ACTION_W-1:0] ACT_SHARE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FAULT   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_SHARED   = 4'd0,
    OUT_COPY     = 4'd1,
    OUT_WRITABLE = 4'd2,
    OUT_NULL     = 4'd3,
    OUT_PROTECT  = 4'd4,
    OUT_NOMEM    = 4'd5,
    OUT_STILL    = 4'd6,
    OUT_FREED    = 4'd7,
    OUT_ABSENT   = 4'd8,
    OUT_RANGE    = 4'd9
  } outcome_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;   // write zero to the entry under the clearing pointer
    logic capture;  // take the input transfer and read its count entry
    logic load;     // finish the item: update the count, fill the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clearing pointer sits on the last entry
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

/* src/cowrc_ctrl.sv */
// Controller state machine of the copy-on-write sharer count engine.
// Depends on cowrc_pkg for the command and status structs.
`timescale 1ns / 1ps

module cowrc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cowrc_pkg::dp_status_t status_i,
  output cowrc_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  state_e state_d;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.clr_en   = (state_q == ST_CLEAR);
  assign cmd_o.capture  = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.load     = (state_q == ST_EXEC) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // A captured item is always worked on in the following cycle.
  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC))
    else $error("captured item did not move to execution");

  // A result blocked by a full output register keeps its place.
  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && !status_i.out_free |=> (state_q == ST_EXEC))
    else $error("item left execution without a free output register");

  // The clearing pass runs to its last entry before items are taken.
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && !status_i.clr_last |=> (state_q == ST_CLEAR))
    else $error("clearing pass ended early");

endmodule

/* src/cowrc_dp.sv */
// Datapath of the copy-on-write sharer count engine: count memory, input
// capture, rule evaluation and output register. Depends on cowrc_pkg.
`timescale 1ns / 1ps

module cowrc_dp #(
  parameter int PAGE_COUNT  = cowrc_pkg::PAGE_COUNT_DEF,
  parameter int SHARE_BIT   = cowrc_pkg::SHARE_BIT_DEF,
  parameter int COUNT_WIDTH = cowrc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cowrc_pkg::ctrl_cmd_t                cmd_i,
  output cowrc_pkg::dp_status_t               status_o,
  input  logic [cowrc_pkg::ACTION_W-1:0]      action_i,
  input  logic [cowrc_pkg::PTE_W-1:0]         pte_word_i,
  input  logic [cowrc_pkg::ADDR_W-1:0]        fault_addr_i,
  input  logic [cowrc_pkg::FRAME_W-1:0]       new_frame_i,
  input  logic                                frame_available_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [cowrc_pkg::PTE_W-1:0]         new_pte_o,
  output logic [cowrc_pkg::OUTCOME_W-1:0]     outcome_o,
  output logic [cowrc_pkg::REPORT_W-1:0]      sharer_count_o,
  output logic                                free_frame_o
);

  localparam int IdxW      = $clog2(PAGE_COUNT);
  localparam int FrameExtW = cowrc_pkg::FRAME_W + 1;
  localparam logic [FrameExtW-1:0] PageLimit = FrameExtW'(PAGE_COUNT);
  localparam logic [IdxW-1:0] ClrLast = IdxW'(PAGE_COUNT - 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CountTwo = COUNT_WIDTH'(2);
  localparam logic [cowrc_pkg::PTE_W-1:0] ShareMask = cowrc_pkg::PTE_W'(1) << SHARE_BIT;
  localparam logic [cowrc_pkg::PTE_W-1:0] WriteMask =
    cowrc_pkg::PTE_W'(1) << cowrc_pkg::BIT_WRITE;
  localparam logic [15:0] ReportMax = 16'd255;

  logic [COUNT_WIDTH-1:0] count_mem [PAGE_COUNT];

  logic [cowrc_pkg::ACTION_W-1:0]  action_q;
  logic [cowrc_pkg::PTE_W-1:0]     pte_q;
  logic [cowrc_pkg::ADDR_W-1:0]    addr_q;
  logic [cowrc_pkg::FRAME_W-1:0]   nframe_q;
  logic                            avail_q;
  logic [COUNT_WIDTH-1:0]          rd_cnt_q;
  logic [IdxW-1:0]                 clr_q;

  logic                            out_valid_q;
  logic [cowrc_pkg::PTE_W-1:0]     out_pte_q;
  logic [cowrc_pkg::OUTCOME_W-1:0] out_outcome_q;
  logic [cowrc_pkg::REPORT_W-1:0]  out_count_q;
  logic                            out_free_q;

  logic [cowrc_pkg::FRAME_W-1:0]   frame;
  logic [cowrc_pkg::FRAME_W-1:0]   in_frame;
  logic                            in_range;
  logic [cowrc_pkg::PTE_W-1:0]     npte;
  cowrc_pkg::outcome_e             outc;
  logic [COUNT_WIDTH-1:0]          cnt_new;
  logic                            cnt_shown;
  logic                            freed;
  logic                            upd;
  logic [15:0]                     cnt_ext;
  logic [cowrc_pkg::REPORT_W-1:0]  report;

  assign frame    = pte_q[cowrc_pkg::PTE_W-1:cowrc_pkg::FRAME_SHIFT];
  assign in_frame = pte_word_i[cowrc_pkg::PTE_W-1:cowrc_pkg::FRAME_SHIFT];
  assign in_range = {1'b0, frame} < PageLimit;

  // Copy-on-write rules, checked in the order the special cases take priority.
  always_comb begin
    npte      = pte_q;
    outc      = cowrc_pkg::OUT_RANGE;
    cnt_new   = rd_cnt_q;
    cnt_shown = 1'b0;
    freed     = 1'b0;
    upd       = 1'b0;
    priority if (action_q != cowrc_pkg::ACT_SHARE && action_q != cowrc_pkg::ACT_FAULT &&
                 action_q != cowrc_pkg::ACT_RELEASE) begin
      outc = cowrc_pkg::OUT_RANGE;
    end else if (action_q == cowrc_pkg::ACT_FAULT && addr_q == '0) begin
      outc = cowrc_pkg::OUT_NULL;
    end else if (!pte_q[cowrc_pkg::BIT_PRESENT]) begin
      outc = cowrc_pkg::OUT_ABSENT;
    end else if (!in_range) begin
      outc = cowrc_pkg::OUT_RANGE;
    end else if (action_q == cowrc_pkg::ACT_SHARE) begin
      cnt_shown = 1'b1;
      upd       = 1'b1;
      outc      = cowrc_pkg::OUT_SHARED;
      npte      = (pte_q & ~WriteMask) | ShareMask;
      if (rd_cnt_q == '0) begin
        cnt_new = CountTwo;
      end else if (rd_cnt_q != CountMax) begin
        cnt_new = rd_cnt_q + CountOne;
      end
    end else if (action_q == cowrc_pkg::ACT_FAULT) begin
      cnt_shown = 1'b1;
      if ((pte_q & ShareMask) == '0) begin
        outc = cowrc_pkg::OUT_PROTECT;
      end else if (rd_cnt_q > CountOne) begin
        if (!avail_q) begin
          outc = cowrc_pkg::OUT_NOMEM;
        end else begin
          outc    = cowrc_pkg::OUT_COPY;
          upd     = 1'b1;
          cnt_new = rd_cnt_q - CountOne;
          npte    = {nframe_q,
                     (pte_q[cowrc_pkg::FLAG_W-1:0] & ~ShareMask[cowrc_pkg::FLAG_W-1:0])
                     | WriteMask[cowrc_pkg::FLAG_W-1:0]};
        end
      end else begin
        outc = cowrc_pkg::OUT_WRITABLE;
        npte = (pte_q | WriteMask) & ~ShareMask;
      end
    end else begin
      cnt_shown = 1'b1;
      upd       = 1'b1;
      npte      = '0;
      if (rd_cnt_q > CountOne) begin
        outc = cowrc_pkg::OUT_STILL;
      end else begin
        outc  = cowrc_pkg::OUT_FREED;
        freed = 1'b1;
      end
      if (rd_cnt_q != '0) begin
        cnt_new = rd_cnt_q - CountOne;
      end
    end
  end

  // Counts wider than the report field saturate at its top value.
  assign cnt_ext = cnt_shown ? 16'(cnt_new) : 16'd0;
  assign report  = (cnt_ext > ReportMax) ? 8'hFF : cnt_ext[cowrc_pkg::REPORT_W-1:0];

  // Count memory: one write port shared by the clearing pass and updates,
  // one registered read port used when an item is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      count_mem[clr_q] <= '0;
    end else if (cmd_i.load && upd) begin
      count_mem[frame[IdxW-1:0]] <= cnt_new;
    end
    if (cmd_i.capture) begin
      rd_cnt_q <= count_mem[in_frame[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      pte_q    <= pte_word_i;
      addr_q   <= fault_addr_i;
      nframe_q <= new_frame_i;
      avail_q  <= frame_available_i;
    end
    if (cmd_i.load) begin
      out_pte_q     <= npte;
      out_outcome_q <= outc;
      out_count_q   <= report;
      out_free_q    <= freed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clr_last = (clr_q == ClrLast);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign new_pte_o      = out_pte_q;
  assign outcome_o      = out_outcome_q;
  assign sharer_count_o = out_count_q;
  assign free_frame_o   = out_free_q;

  // A finished item always shows up on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("finished item missing from the output register");

  // The clearing pass and a count update never contend for the write port.
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_en && (cmd_i.load || cmd_i.capture)))
    else $error("clearing pass overlaps item processing");

  // Only a release can hand a frame back to the allocator.
  a_free_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && freed |-> (action_q == cowrc_pkg::ACT_RELEASE) && (npte == '0))
    else $error("frame freed outside a release");

endmodule

/* src/cow_page_refcount_engine.sv */
// Top level of the copy-on-write page sharer count engine.
// Instantiates cowrc_ctrl and cowrc_dp; depends on cowrc_pkg.
`timescale 1ns / 1ps

// Usage:
// Each input transfer on the s_axis channel carries one page table entry and
// the action to apply to it (share for fork, write fault, release). The block
// keeps one sharer count per physical page in an internal memory, applies the
// copy-on-write rules and returns exactly one result transfer on m_axis: the
// entry to write back, an outcome code, the page's sharer count after the
// step and a flag asking for the old frame to be freed.
// An accepted transfer is captured into the input registers, and its result is
// loaded into the output register once that register is free. The block takes no
// new item until then, set by the read-modify-write of the count memory: the entry
// is read when the item is taken and written back when its result is loaded.
// The result sits in an output register, so a stalled receiver only holds
// the block once a second result is ready; s_axis_tready stays low until the
// waiting result has been taken.
// Reset: after rst_ni is released the block clears the count memory one entry
// per cycle; s_axis_tready stays low during this clearing pass.
module cow_page_refcount_engine #(
  parameter int PAGE_COUNT  = cowrc_pkg::PAGE_COUNT_DEF,
  parameter int SHARE_BIT   = cowrc_pkg::SHARE_BIT_DEF,
  parameter int COUNT_WIDTH = cowrc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Bits 31:0 pte_word, 63:32 fault_addr, 83:64 new_frame,
  // 84 frame_available, 87:85 zero.
  input  logic [cowrc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // Bits 1:0 action.
  input  logic [cowrc_pkg::ACTION_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Bits 31:0 new_pte, 39:32 sharer_count, 40 free_frame, 47:41 zero.
  output logic [cowrc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // Bits 3:0 outcome.
  output logic [cowrc_pkg::OUTCOME_W-1:0]    m_axis_tuser
);

  cowrc_pkg::ctrl_cmd_t  cmd;
  cowrc_pkg::dp_status_t status;

  logic [cowrc_pkg::PTE_W-1:0]    new_pte;
  logic [cowrc_pkg::REPORT_W-1:0] sharer_count;
  logic                           free_frame;

  // The controller sequences clearing, capture and completion of each item.
  cowrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the count memory, the rules and the output register.
  cowrc_dp #(
    .PAGE_COUNT  (PAGE_COUNT),
    .SHARE_BIT   (SHARE_BIT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .action_i          (s_axis_tuser),
    .pte_word_i        (s_axis_tdata[31:0]),
    .fault_addr_i      (s_axis_tdata[63:32]),
    .new_frame_i       (s_axis_tdata[83:64]),
    .frame_available_i (s_axis_tdata[84]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .new_pte_o         (new_pte),
    .outcome_o         (m_axis_tuser),
    .sharer_count_o    (sharer_count),
    .free_frame_o      (free_frame)
  );

  // Result fields packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata = {7'd0, free_frame, sharer_count, new_pte};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for cow_page_refcount_engine: drives page table entries over s_axis
// and compares every m_axis result against a predictor that mirrors the sharer count table.
// Depends on cowrc_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_top;

  localparam int COUNT_W    = cowrc_pkg::COUNT_WIDTH_DEF;
  localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
  localparam int REPORT_MAX = (1 << cowrc_pkg::REPORT_W) - 1;
  localparam int IDX_W      = $clog2(cowrc_pkg::PAGE_COUNT_DEF);
  localparam int MW         = cowrc_pkg::M_TDATA_W;
  localparam int N_ITEMS    = 1850;
  localparam int SEG_LEN    = 60;
  localparam int CYCLE_LIMIT = 600000;

  // Action value the block must report as out of range.
  localparam logic [cowrc_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [cowrc_pkg::FLAG_W-1:0] PRESENT_M =
    cowrc_pkg::FLAG_W'(1) << cowrc_pkg::BIT_PRESENT;
  localparam logic [cowrc_pkg::FLAG_W-1:0] WRITE_M =
    cowrc_pkg::FLAG_W'(1) << cowrc_pkg::BIT_WRITE;
  localparam logic [cowrc_pkg::FLAG_W-1:0] SHARE_M =
    cowrc_pkg::FLAG_W'(1) << cowrc_pkg::SHARE_BIT_DEF;

  typedef enum int {MODE_MIX, MODE_HOT, MODE_DRAIN} traffic_mode_e;

  typedef struct {
    logic [cowrc_pkg::ACTION_W-1:0] action;
    logic [cowrc_pkg::PTE_W-1:0]    pte;
    logic [cowrc_pkg::ADDR_W-1:0]   addr;
    logic [cowrc_pkg::FRAME_W-1:0]  nframe;
    logic                           avail;
  } page_req_t;

  // Keeps its own copy of the sharer count table and a FIFO of the results
  // that accepted requests must produce.
  class cow_scoreboard;
    typedef struct {
      logic [cowrc_pkg::PTE_W-1:0]    pte;
      cowrc_pkg::outcome_e            outcome;
      logic [cowrc_pkg::REPORT_W-1:0] count;
      logic                           free_flag;
    } page_result_t;

    bit [COUNT_W-1:0] share_tbl [cowrc_pkg::PAGE_COUNT_DEF];
    page_result_t     expected_q[$];
    int               mismatches;
    int               checked;
    int               saturated_hits;
    int               outcome_hits[10];

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(page_req_t req);
      page_result_t                  res;
      logic [cowrc_pkg::FRAME_W-1:0] frame;
      int                            cnt;
      frame         = req.pte[cowrc_pkg::PTE_W-1:cowrc_pkg::FRAME_SHIFT];
      res.pte       = req.pte;
      res.free_flag = 1'b0;
      cnt           = 0;
      if (req.action != cowrc_pkg::ACT_SHARE && req.action != cowrc_pkg::ACT_FAULT &&
          req.action != cowrc_pkg::ACT_RELEASE) begin
        res.outcome = cowrc_pkg::OUT_RANGE;
      end else if (req.action == cowrc_pkg::ACT_FAULT && req.addr == '0) begin
        res.outcome = cowrc_pkg::OUT_NULL;
      end else if (!req.pte[cowrc_pkg::BIT_PRESENT]) begin
        res.outcome = cowrc_pkg::OUT_ABSENT;
      end else if (int'(frame) >= cowrc_pkg::PAGE_COUNT_DEF) begin
        res.outcome = cowrc_pkg::OUT_RANGE;
      end else begin
        cnt = share_tbl[frame[IDX_W-1:0]];
        case (req.action)
          cowrc_pkg::ACT_SHARE: begin
            res.pte = (req.pte & ~32'(WRITE_M)) | 32'(SHARE_M);
            if (cnt == 0) cnt = 2;
            else if (cnt < COUNT_MAX) cnt = cnt + 1;
            share_tbl[frame[IDX_W-1:0]] = COUNT_W'(cnt);
            res.outcome = cowrc_pkg::OUT_SHARED;
          end
          cowrc_pkg::ACT_FAULT: begin
            if (!(req.pte & 32'(SHARE_M))) begin
              res.outcome = cowrc_pkg::OUT_PROTECT;
            end else if (cnt > 1) begin
              if (!req.avail) begin
                res.outcome = cowrc_pkg::OUT_NOMEM;
              end else begin
                // The copy lands in the new frame and leaves the shared page with one less.
                res.pte = (32'(req.nframe) << cowrc_pkg::FRAME_SHIFT)
                        | 32'((req.pte[cowrc_pkg::FLAG_W-1:0] & ~SHARE_M) | WRITE_M);
                cnt = cnt - 1;
                share_tbl[frame[IDX_W-1:0]] = COUNT_W'(cnt);
                res.outcome = cowrc_pkg::OUT_COPY;
              end
            end else begin
              res.pte = (req.pte | 32'(WRITE_M)) & ~32'(SHARE_M);
              res.outcome = cowrc_pkg::OUT_WRITABLE;
            end
          end
          default: begin
            res.pte = '0;
            if (cnt > 1) begin
              res.outcome = cowrc_pkg::OUT_STILL;
            end else begin
              res.outcome   = cowrc_pkg::OUT_FREED;
              res.free_flag = 1'b1;
            end
            if (cnt > 0) cnt = cnt - 1;
            share_tbl[frame[IDX_W-1:0]] = COUNT_W'(cnt);
          end
        endcase
      end
      if (cnt == COUNT_MAX) saturated_hits++;
      res.count = cowrc_pkg::REPORT_W'((cnt > REPORT_MAX) ? REPORT_MAX : cnt);
      outcome_hits[res.outcome]++;
      expected_q.push_back(res);
    endfunction

    // Printing stops after the first few dozen so a broken block cannot flood the log.
    task report_mismatch(string field, logic [MW-1:0] got, logic [MW-1:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch in %s: got %0h, expected %0h (result %0d)", field, got, want,
                 checked);
    endtask

    task check_result(logic [MW-1:0] data, logic [cowrc_pkg::OUTCOME_W-1:0] user);
      page_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", data, '0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (data[31:0] !== want.pte)
        report_mismatch("new_pte", MW'(data[31:0]), MW'(want.pte));
      if (user !== want.outcome)
        report_mismatch("outcome", MW'(user), MW'(want.outcome));
      if (data[39:32] !== want.count)
        report_mismatch("sharer_count", MW'(data[39:32]), MW'(want.count));
      if (data[40] !== want.free_flag)
        report_mismatch("free_frame", MW'(data[40]), MW'(want.free_flag));
      if (data[47:41] !== '0) report_mismatch("tdata padding", MW'(data[47:41]), '0);
    endtask
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [cowrc_pkg::S_TDATA_W-1:0]     s_axis_tdata = '0;
  logic [cowrc_pkg::ACTION_W-1:0]      s_axis_tuser = cowrc_pkg::ACT_SHARE;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [cowrc_pkg::M_TDATA_W-1:0]     m_axis_tdata;
  logic [cowrc_pkg::OUTCOME_W-1:0]     m_axis_tuser;

  cow_scoreboard sb = new();
  int            items_sent;
  int            cycle_cnt;
  int            rx_mode;
  int            rx_tick;
  logic [cowrc_pkg::FRAME_W-1:0] frame_pool[6];

  cow_page_refcount_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: the stall pattern is drawn at random, each time rx_tick wraps, among always ready,
  // coin flips, mostly stalled and mostly ready.
  always @(negedge clk_i) begin
    if (rx_tick == 0) rx_mode = $urandom_range(0, 3);
    rx_tick = (rx_tick + 1) % 48;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 6) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  function automatic page_req_t mk_req(logic [cowrc_pkg::ACTION_W-1:0] action,
                                       logic [cowrc_pkg::FRAME_W-1:0] frame,
                                       logic [cowrc_pkg::FLAG_W-1:0] flags,
                                       logic [cowrc_pkg::ADDR_W-1:0] addr,
                                       logic [cowrc_pkg::FRAME_W-1:0] nframe, logic avail);
    page_req_t req;
    req.action = action;
    req.pte    = {frame, flags};
    req.addr   = addr;
    req.nframe = nframe;
    req.avail  = avail;
    return req;
  endfunction

  // Mostly well-formed requests on a small pool of frames so counts build up,
  // with absent entries, null faults, unshared faults and bad frames mixed in.
  function automatic page_req_t random_req(traffic_mode_e mode);
    page_req_t                     req;
    int                            roll;
    logic [cowrc_pkg::FRAME_W-1:0] frame;
    logic [cowrc_pkg::FLAG_W-1:0]  flags;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_HOT:   req.action = (roll < 88) ? cowrc_pkg::ACT_SHARE :
                               (roll < 93) ? cowrc_pkg::ACT_FAULT :
                               (roll < 98) ? cowrc_pkg::ACT_RELEASE : ACT_UNUSED;
      MODE_DRAIN: req.action = (roll < 10) ? cowrc_pkg::ACT_SHARE :
                               (roll < 25) ? cowrc_pkg::ACT_FAULT :
                               (roll < 97) ? cowrc_pkg::ACT_RELEASE : ACT_UNUSED;
      default:    req.action = (roll < 35) ? cowrc_pkg::ACT_SHARE :
                               (roll < 70) ? cowrc_pkg::ACT_FAULT :
                               (roll < 95) ? cowrc_pkg::ACT_RELEASE : ACT_UNUSED;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 4)
      frame = cowrc_pkg::FRAME_W'($urandom_range(20'hFFFFF, cowrc_pkg::PAGE_COUNT_DEF));
    else if (mode == MODE_HOT && roll < 96) frame = frame_pool[2];
    else frame = frame_pool[$urandom_range(0, 5)];
    flags = cowrc_pkg::FLAG_W'($urandom_range(0, 12'hFFF));
    flags[cowrc_pkg::BIT_PRESENT] = ($urandom_range(0, 19) != 0);
    if (req.action == cowrc_pkg::ACT_FAULT)
      flags[cowrc_pkg::SHARE_BIT_DEF] = ($urandom_range(0, 99) < 85);
    req.pte    = {frame, flags};
    req.addr   = ($urandom_range(0, 24) == 0) ? '0 : $urandom;
    req.nframe = cowrc_pkg::FRAME_W'($urandom_range(0, 20'hFFFFF));
    req.avail  = ($urandom_range(0, 7) != 0);
    return req;
  endfunction

  task automatic send_req(page_req_t req);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, req.avail, req.nframe, req.addr, req.pte};
    s_axis_tuser  <= req.action;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_input(req);
    items_sent++;
  endtask

  task automatic idle_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_gap(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    page_req_t                     directed[$];
    traffic_mode_e                 mode;
    int                            seg;
    int                            burst_left;
    string                         hits;
    logic [cowrc_pkg::FRAME_W-1:0] top_frame;
    logic [cowrc_pkg::FRAME_W-1:0] past_frame;

    top_frame  = cowrc_pkg::FRAME_W'(cowrc_pkg::PAGE_COUNT_DEF - 1);
    past_frame = cowrc_pkg::FRAME_W'(cowrc_pkg::PAGE_COUNT_DEF);
    frame_pool[0] = '0;
    frame_pool[1] = top_frame;
    for (int i = 2; i < 6; i++)
      frame_pool[i] = cowrc_pkg::FRAME_W'($urandom_range(1, cowrc_pkg::PAGE_COUNT_DEF - 2));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk one page through its whole life, then the corner entries.
    directed.push_back(mk_req(cowrc_pkg::ACT_SHARE, '0, PRESENT_M | WRITE_M, 32'h1000, '0,
                              1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_SHARE, '0, PRESENT_M | WRITE_M, 32'h1000, '0,
                              1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, PRESENT_M | SHARE_M, 32'h1000, 20'h1,
                              1'b0));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, PRESENT_M | SHARE_M, 32'h1000,
                              20'hFFFFF, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, PRESENT_M | SHARE_M, '0, 20'h2, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, PRESENT_M, 32'h2000, 20'h3, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_RELEASE, '0, PRESENT_M | SHARE_M, 32'h1000, '0,
                              1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, PRESENT_M | SHARE_M, 32'h1000, 20'h4,
                              1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_RELEASE, '0, PRESENT_M | WRITE_M, 32'h1000, '0,
                              1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_RELEASE, '0, PRESENT_M, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, PRESENT_M | SHARE_M, 32'h1000, 20'h5,
                              1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_SHARE, '0, 12'hFFE, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_RELEASE, '0, '0, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, SHARE_M, 32'hFFFF_FFFF, 20'h6, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, '0, '0, 20'h7, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_SHARE, top_frame, 12'hFFF, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, top_frame, 12'hFFF, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_RELEASE, top_frame, 12'hFFF, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_SHARE, past_frame, PRESENT_M, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(cowrc_pkg::ACT_RELEASE, 20'hFFFFF, 12'hFFF, 32'h1000, '0, 1'b1));
    directed.push_back(mk_req(ACT_UNUSED, 20'hFFFFF, 12'hFFF, '0, 20'hFFFFF, 1'b1));
    directed.push_back(mk_req(ACT_UNUSED, '0, '0, 32'h1000, '0, 1'b0));
    directed.push_back(mk_req(cowrc_pkg::ACT_FAULT, '0, PRESENT_M | SHARE_M, 32'hFFFF_FFFF,
                              20'h12345, 1'b1));
    foreach (directed[i]) begin
      send_req(directed[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
    end
    wait_drained();

    // Random traffic in segments; the hot frame is pushed towards saturation,
    // drain segments pull the pool back down to the floor.
    seg = 0;
    burst_left = 0;
    while (items_sent < N_ITEMS) begin
      case (seg % 4)
        0, 2:    mode = MODE_HOT;
        1:       mode = MODE_MIX;
        default: mode = MODE_DRAIN;
      endcase
      if (seg % 4 == 1) mode = ($urandom_range(0, 1) == 0) ? MODE_MIX : MODE_DRAIN;
      for (int k = 0; k < SEG_LEN && items_sent < N_ITEMS; k++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
          burst_left = $urandom_range(1, 20);
        end
        send_req(random_req(mode));
        burst_left--;
      end
      if (seg == 12) wait_drained();
      seg++;
    end

    wait_drained();
    repeat (16) @(posedge clk_i);

    hits = "";
    for (int i = 0; i < 10; i++) hits = {hits, $sformatf(" %0d", sb.outcome_hits[i])};
    $display("covered %0d requests, %0d results checked, %0d at the count ceiling",
             items_sent, sb.checked, sb.saturated_hits);
    $display("outcomes shared..range:%s", hits);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
